// ===== rtl/cmm_pkg.sv =====
package cmm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = 3;
   localparam int DIM_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int ADDR_MAX_W = 2 * IDX_W;
   localparam int ACC_W      = 72;

   typedef enum logic [1:0] {
      REQ_LOAD_A  = 2'd0,
      REQ_LOAD_B  = 2'd1,
      REQ_COMPUTE = 2'd2
   } cmm_req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_ROWS = 2'd0,
      CSR_A_COLS = 2'd1,
      CSR_B_ROWS = 2'd2,
      CSR_B_COLS = 2'd3
   } cmm_csr_code_type;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [IDX_W-1:0]         elem_row;
      logic [IDX_W-1:0]         elem_col;
      logic signed [DATA_W-1:0] elem_re;
      logic signed [DATA_W-1:0] elem_im;
   } cmm_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_row;
      logic [IDX_W-1:0]         out_col;
      logic signed [DATA_W-1:0] out_re;
      logic signed [DATA_W-1:0] out_im;
      logic                     dim_mismatch;
      logic                     last;
   } cmm_rsp_type;

   typedef struct packed {
      logic                  wr_a;
      logic                  wr_b;
      logic [ADDR_MAX_W-1:0] wr_addr;
      logic                  rd_en;
      logic                  mac_en;
      logic [ADDR_MAX_W-1:0] a_addr;
      logic [ADDR_MAX_W-1:0] b_addr;
      logic                  acc_clear;
      logic                  emit;
      logic                  mismatch;
      logic [IDX_W-1:0]      out_row;
      logic [IDX_W-1:0]      out_col;
      logic                  last;
   } cmm_cmd_type;

   typedef struct packed {
      logic out_free;
   } cmm_stat_type;

endpackage

// ===== rtl/cmm_ctrl.sv =====
module cmm_ctrl #(
   parameter int MAX_DIM = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cmm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cmm_pkg::DIM_W-1:0]        csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cmm_pkg::cmm_req_type             req_payload,
   output cmm_pkg::cmm_cmd_type             cmd,
   input  cmm_pkg::cmm_stat_type            stat
);
   import cmm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   localparam int CALC_W = ADDR_MAX_W + 4;

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] a_rows_ff, a_rows_in;
   logic [DIM_W-1:0] a_cols_ff, a_cols_in;
   logic [DIM_W-1:0] b_rows_ff, b_rows_in;
   logic [DIM_W-1:0] b_cols_ff, b_cols_in;
   logic             mis_ff, mis_in;
   logic [DIM_W-1:0] rows_ff, rows_in;
   logic [DIM_W-1:0] cols_ff, cols_in;
   logic [DIM_W-1:0] steps_ff, steps_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             drain_ff, drain_in;

   logic [DIM_W-1:0] ar, ac, br, bc;
   logic             mis_now;
   logic             row_end, col_end;
   logic             in_store;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
   endfunction

   function automatic logic [ADDR_MAX_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                     input logic [IDX_W-1:0] c);
      logic [CALC_W-1:0] full;
      full = CALC_W'(r) * CALC_W'(MAX_DIM) + CALC_W'(c);
      return full[ADDR_MAX_W-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);

   assign ar      = eff_dim(a_rows_ff);
   assign ac      = eff_dim(a_cols_ff);
   assign br      = eff_dim(b_rows_ff);
   assign bc      = eff_dim(b_cols_ff);
   assign mis_now = (ac != br);
   assign row_end = (DIM_W'(i_ff) + DIM_W'(1)) == rows_ff;
   assign col_end = (DIM_W'(j_ff) + DIM_W'(1)) == cols_ff;
   assign in_store = (DIM_W'(req_payload.elem_row) < DIM_W'(MAX_DIM)) &&
                     (DIM_W'(req_payload.elem_col) < DIM_W'(MAX_DIM));

   always_comb begin
      state_in  = state_ff;
      a_rows_in = a_rows_ff;
      a_cols_in = a_cols_ff;
      b_rows_in = b_rows_ff;
      b_cols_in = b_cols_ff;
      mis_in    = mis_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      steps_in  = steps_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      drain_in  = drain_ff;
      cmd       = '0;
      cmd.wr_addr  = addr_of(req_payload.elem_row, req_payload.elem_col);
      cmd.a_addr   = mis_ff ? addr_of(i_ff, j_ff) : addr_of(i_ff, k_ff);
      cmd.b_addr   = addr_of(k_ff, j_ff);
      cmd.out_row  = i_ff;
      cmd.out_col  = j_ff;
      cmd.mismatch = mis_ff;
      cmd.last     = row_end && col_end;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_A_ROWS: a_rows_in = csr_wdata;
            CSR_A_COLS: a_cols_in = csr_wdata;
            CSR_B_ROWS: b_rows_in = csr_wdata;
            CSR_B_COLS: b_cols_in = csr_wdata;
            default:    a_rows_in = a_rows_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_payload.req_type)
                  REQ_LOAD_A: cmd.wr_a = in_store;
                  REQ_LOAD_B: cmd.wr_b = in_store;
                  REQ_COMPUTE: begin
                     mis_in   = mis_now;
                     rows_in  = ar;
                     cols_in  = mis_now ? ac : bc;
                     steps_in = mis_now ? DIM_W'(1) : ac;
                     i_in     = '0;
                     j_in     = '0;
                     if (ar != '0 && (mis_now ? ac : bc) != '0) begin
                        state_in = ST_START;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_START: begin
            cmd.acc_clear = 1'b1;
            k_in          = '0;
            drain_in      = 1'b0;
            state_in      = (steps_ff == '0) ? ST_DRAIN : ST_RUN;
         end
         ST_RUN: begin
            cmd.rd_en  = 1'b1;
            cmd.mac_en = !mis_ff;
            k_in       = k_ff + IDX_W'(1);
            if ((DIM_W'(k_ff) + DIM_W'(1)) == steps_ff) begin
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = stat.out_free;
            if (stat.out_free) begin
               if (row_end && col_end) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_START;
                  if (col_end) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         a_rows_ff <= DIM_W'(2);
         a_cols_ff <= DIM_W'(2);
         b_rows_ff <= DIM_W'(2);
         b_cols_ff <= DIM_W'(2);
         mis_ff    <= 1'b0;
         rows_ff   <= '0;
         cols_ff   <= '0;
         steps_ff  <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         drain_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         a_rows_ff <= a_rows_in;
         a_cols_ff <= a_cols_in;
         b_rows_ff <= b_rows_in;
         b_cols_ff <= b_cols_in;
         mis_ff    <= mis_in;
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         steps_ff  <= steps_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         drain_ff  <= drain_in;
      end
   end

endmodule

// ===== rtl/cmm_datapath.sv =====
module cmm_datapath #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmm_pkg::cmm_req_type  req_payload,
   input  cmm_pkg::cmm_cmd_type  cmd,
   output cmm_pkg::cmm_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cmm_pkg::cmm_rsp_type  rsp_payload
);
   import cmm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ELEM_W = 2 * DATA_W;
   localparam int PROD_W = 2 * DATA_W;

   logic [ELEM_W-1:0] a_mem [DEPTH];
   logic [ELEM_W-1:0] b_mem [DEPTH];

   logic [ELEM_W-1:0]        a_rd_ff, b_rd_ff;
   logic                     rd_valid_ff;
   logic                     prod_valid_ff;
   logic signed [PROD_W-1:0] prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_im_ff;
   logic                     rsp_valid_ff;
   cmm_rsp_type              rsp_ff, rsp_in;

   logic signed [DATA_W-1:0] a_re, a_im, b_re, b_im;

   function automatic logic [DATA_W-1:0] finish(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] s;
      s = v >>> FRAC_BITS;
      if ((&s[ACC_W-1:DATA_W-1]) || !(|s[ACC_W-1:DATA_W-1])) begin
         return s[DATA_W-1:0];
      end
      return s[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         a_mem[cmd.wr_addr[ADDR_W-1:0]] <= {req_payload.elem_re, req_payload.elem_im};
      end
      if (cmd.rd_en) begin
         a_rd_ff <= a_mem[cmd.a_addr[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_b) begin
         b_mem[cmd.wr_addr[ADDR_W-1:0]] <= {req_payload.elem_re, req_payload.elem_im};
      end
      if (cmd.rd_en) begin
         b_rd_ff <= b_mem[cmd.b_addr[ADDR_W-1:0]];
      end
   end

   assign a_re = a_rd_ff[ELEM_W-1:DATA_W];
   assign a_im = a_rd_ff[DATA_W-1:0];
   assign b_re = b_rd_ff[ELEM_W-1:DATA_W];
   assign b_im = b_rd_ff[DATA_W-1:0];

   always_ff @(posedge clock) begin
      prr_ff <= a_re * b_re;
      pii_ff <= a_im * b_im;
      pri_ff <= a_re * b_im;
      pir_ff <= a_im * b_re;
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prr_ff) - ACC_W'(pii_ff);
         acc_im_ff <= acc_im_ff + ACC_W'(pri_ff) + ACC_W'(pir_ff);
      end
   end

   always_comb begin
      rsp_in.out_row      = cmd.out_row;
      rsp_in.out_col      = cmd.out_col;
      rsp_in.dim_mismatch = cmd.mismatch;
      rsp_in.last         = cmd.last;
      if (cmd.mismatch) begin
         rsp_in.out_re = a_re;
         rsp_in.out_im = a_im;
      end else begin
         rsp_in.out_re = finish(acc_re_ff);
         rsp_in.out_im = finish(acc_im_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.rd_en && cmd.mac_en;
         prod_valid_ff <= rd_valid_ff;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;

endmodule

// ===== rtl/complex_matrix_multiply_top.sv =====
// complex matrix multiplier, signed fixed-point parts
// requests on req_*: load A element, load B element, or compute; a load
//   leaves the block idle, so the next request may follow in the next cycle
// a compute request emits C = A * B on rsp_* in row-major order, last
//   flagged; when A's columns differ from B's rows, A is sent instead with
//   dim_mismatch set
// each result: a clear step, then one complex multiply-accumulate per cycle
//   through a single four-multiplier unit fed by one read port on each store,
//   a drain while the read and product registers empty, then an emit step;
//   a pass-through result makes a single read and no multiply-accumulate
// req_stall stays high until the last result of a compute is registered
// csr_* writes the four dimension registers, always ready; the user must
//   write them only while idle, which the block itself does not enforce
// reset clears the controller and the output valid flag, sets all dimensions to 2;
//   element stores keep whatever they hold until loaded
// when the receiver stalls, the result holds in the output register and the
//   next one is computed and waits behind it
module complex_matrix_multiply_top #(
   parameter int MAX_DIM   = cmm_pkg::MAX_DIM,
   parameter int FRAC_BITS = cmm_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cmm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cmm_pkg::DIM_W-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cmm_pkg::cmm_req_type          req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cmm_pkg::cmm_rsp_type          rsp_payload
);
   import cmm_pkg::*;

   cmm_cmd_type  cmd;
   cmm_stat_type stat;

   cmm_ctrl #(
      .MAX_DIM(MAX_DIM)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

   cmm_datapath #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/cmm_checker.sv =====
module cmm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input cmm_pkg::cmm_req_type req_payload,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input cmm_pkg::cmm_rsp_type rsp_payload
);
   import cmm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.req_type != REQ_COMPUTE |=> !req_stall)
      else $error("load request left the block busy");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> req_stall)
      else $error("request taken in the middle of a run");

endmodule

bind complex_matrix_multiply_top cmm_checker u_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
   import cmm_pkg::*;

   localparam int          SUM_W         = 80;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          LONG_HOLD     = 250;
   localparam int          SETTLE_CYCLES = 32;
   localparam logic [1:0]  REQ_UNUSED    = 2'd3;
   localparam logic signed [SUM_W-1:0] SUM_QMAX = (80'sd1 <<< (DATA_W - 1)) - 80'sd1;
   localparam logic signed [SUM_W-1:0] SUM_QMIN = -(80'sd1 <<< (DATA_W - 1));

   typedef struct {
      cmm_req_type body;
      int unsigned gap;
   } queued_req_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_A_ROWS;
   logic [DIM_W-1:0]     csr_wdata   = '0;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   cmm_req_type          req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   cmm_rsp_type          rsp_payload;

   queued_req_type       pending_reqs[$];
   queued_req_type       next_req;
   cmm_rsp_type          due_elems[$];
   cmm_rsp_type          next_due;

   logic [DIM_W-1:0]     cfg_dims [4];
   logic [2*DATA_W-1:0]  a_mem [MAX_DIM*MAX_DIM];
   logic [2*DATA_W-1:0]  b_mem [MAX_DIM*MAX_DIM];
   bit                   gen_a_set [MAX_DIM*MAX_DIM];
   bit                   gen_b_set [MAX_DIM*MAX_DIM];

   bit                   req_taken   = 1'b0;
   bit                   rsp_taken   = 1'b0;
   bit                   burst_mode  = 1'b0;
   bit                   rsp_eager   = 1'b0;
   bit                   hold_armed  = 1'b0;
   bit                   hold_spent  = 1'b0;
   int unsigned          idle_count  = 0;
   int unsigned          rsp_wait    = 0;
   int unsigned          hold_left   = 0;
   int unsigned          cycle_count = 0;
   int unsigned          fail_count  = 0;
   int unsigned          reqs_done   = 0;
   int unsigned          runs_done   = 0;
   int unsigned          elems_seen  = 0;
   int unsigned          passthru    = 0;
   int unsigned          dim_sets    = 0;

   complex_matrix_multiply_top DUT (
      .clock,
      .reset,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata,
      .req_valid,
      .req_stall,
      .req_payload,
      .rsp_valid,
      .rsp_stall,
      .rsp_payload
   );

   always #1 clock = ~clock;

   initial begin
      cfg_dims = '{4'd2, 4'd2, 4'd2, 4'd2};
   end

   function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : v;
   endfunction

   function automatic logic signed [DATA_W-1:0] to_q16(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-1:0] scaled;
      scaled = sum >>> FRAC_BITS;
      if (scaled > SUM_QMAX)
         return SUM_QMAX[DATA_W-1:0];
      if (scaled < SUM_QMIN)
         return SUM_QMIN[DATA_W-1:0];
      return scaled[DATA_W-1:0];
   endfunction

   function automatic void predict_product();
      int unsigned              ar, ac, br, bc;
      logic signed [SUM_W-1:0]  acc_re, acc_im;
      logic signed [DATA_W-1:0] xr, xi, yr, yi;
      cmm_rsp_type              elem;
      ar = eff_dim(cfg_dims[CSR_A_ROWS]);
      ac = eff_dim(cfg_dims[CSR_A_COLS]);
      br = eff_dim(cfg_dims[CSR_B_ROWS]);
      bc = eff_dim(cfg_dims[CSR_B_COLS]);
      if (ac != br) begin
         for (int unsigned i = 0; i < ar; i++) begin
            for (int unsigned j = 0; j < ac; j++) begin
               elem              = '0;
               elem.out_row      = IDX_W'(i);
               elem.out_col      = IDX_W'(j);
               elem.out_re       = a_mem[i*MAX_DIM+j][2*DATA_W-1:DATA_W];
               elem.out_im       = a_mem[i*MAX_DIM+j][DATA_W-1:0];
               elem.dim_mismatch = 1'b1;
               elem.last         = (i + 1 == ar) && (j + 1 == ac);
               due_elems = {due_elems, elem};
            end
         end
      end else begin
         for (int unsigned i = 0; i < ar; i++) begin
            for (int unsigned j = 0; j < bc; j++) begin
               acc_re = '0;
               acc_im = '0;
               for (int unsigned k = 0; k < ac; k++) begin
                  xr = a_mem[i*MAX_DIM+k][2*DATA_W-1:DATA_W];
                  xi = a_mem[i*MAX_DIM+k][DATA_W-1:0];
                  yr = b_mem[k*MAX_DIM+j][2*DATA_W-1:DATA_W];
                  yi = b_mem[k*MAX_DIM+j][DATA_W-1:0];
                  acc_re = acc_re + xr * yr - xi * yi;
                  acc_im = acc_im + xr * yi + xi * yr;
               end
               elem              = '0;
               elem.out_row      = IDX_W'(i);
               elem.out_col      = IDX_W'(j);
               elem.out_re       = to_q16(acc_re);
               elem.out_im       = to_q16(acc_im);
               elem.dim_mismatch = 1'b0;
               elem.last         = (i + 1 == ar) && (j + 1 == bc);
               due_elems = {due_elems, elem};
            end
         end
      end
   endfunction

   function automatic void apply_request(input cmm_req_type r);
      int unsigned slot;
      slot = r.elem_row * MAX_DIM + r.elem_col;
      case (r.req_type)
         REQ_LOAD_A: a_mem[slot] = {r.elem_re, r.elem_im};
         REQ_LOAD_B: b_mem[slot] = {r.elem_re, r.elem_im};
         REQ_COMPUTE: begin
            runs_done++;
            predict_product();
         end
         default: ;
      endcase
   endfunction

   function automatic void check_part(input string name, input logic [DATA_W-1:0] want_v,
                                      input logic [DATA_W-1:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0h, actual %0h", name, want_v, got_v);
         fail_count++;
      end
   endfunction

   function automatic logic [DATA_W-1:0] draw_part();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom();
         4, 5, 6, 7: return DATA_W'($urandom_range(0, 32'h80000)) - 32'h40000;
         default: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFFFFFF;
               1: return 32'h80000000;
               2: return 32'h00000000;
               3: return 32'hFFFFFFFF;
               default: return 32'h00010000;
            endcase
         end
      endcase
   endfunction

   function automatic int unsigned draw_pos(input int unsigned limit);
      if (limit == 0 || $urandom_range(0, 3) == 0)
         return $urandom_range(0, MAX_DIM - 1);
      return $urandom_range(0, limit - 1);
   endfunction

   function automatic void queue_req(input logic [1:0] kind, input int unsigned row,
                                     input int unsigned col, input logic [DATA_W-1:0] re,
                                     input logic [DATA_W-1:0] im);
      queued_req_type q;
      q.body.req_type = kind;
      q.body.elem_row = IDX_W'(row);
      q.body.elem_col = IDX_W'(col);
      q.body.elem_re  = re;
      q.body.elem_im  = im;
      q.gap           = burst_mode ? 0 : $urandom_range(0, 6);
      pending_reqs = {pending_reqs, q};
      if (kind == REQ_LOAD_A)
         gen_a_set[row*MAX_DIM+col] = 1'b1;
      if (kind == REQ_LOAD_B)
         gen_b_set[row*MAX_DIM+col] = 1'b1;
   endfunction

   // loads every entry the product reads that was never written, then the compute
   function automatic void queue_compute();
      int unsigned ar, ac, br, bc;
      ar = eff_dim(cfg_dims[CSR_A_ROWS]);
      ac = eff_dim(cfg_dims[CSR_A_COLS]);
      br = eff_dim(cfg_dims[CSR_B_ROWS]);
      bc = eff_dim(cfg_dims[CSR_B_COLS]);
      for (int unsigned i = 0; i < ar; i++)
         for (int unsigned j = 0; j < ac; j++)
            if (!gen_a_set[i*MAX_DIM+j])
               queue_req(REQ_LOAD_A, i, j, draw_part(), draw_part());
      if (ac == br) begin
         for (int unsigned k = 0; k < br; k++)
            for (int unsigned j = 0; j < bc; j++)
               if (!gen_b_set[k*MAX_DIM+j])
                  queue_req(REQ_LOAD_B, k, j, draw_part(), draw_part());
      end
      queue_req(REQ_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), draw_part(),
                draw_part());
   endfunction

   function automatic void queue_random(input int n);
      int unsigned ar, ac, br, bc, pick;
      ar = eff_dim(cfg_dims[CSR_A_ROWS]);
      ac = eff_dim(cfg_dims[CSR_A_COLS]);
      br = eff_dim(cfg_dims[CSR_B_ROWS]);
      bc = eff_dim(cfg_dims[CSR_B_COLS]);
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            queue_req(REQ_LOAD_A, draw_pos(ar), draw_pos(ac), draw_part(), draw_part());
         else if (pick < 80)
            queue_req(REQ_LOAD_B, draw_pos(br), draw_pos(bc), draw_part(), draw_part());
         else if (pick < 96)
            queue_compute();
         else
            queue_req(REQ_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), draw_part(),
                      draw_part());
      end
   endfunction

   function automatic logic [DIM_W-1:0] rand_dim();
      if ($urandom_range(0, 7) == 0)
         return DIM_W'($urandom_range(0, 15));
      return DIM_W'($urandom_range(1, 5));
   endfunction

   task automatic write_dim(input cmm_csr_code_type idx, input logic [DIM_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      cfg_dims[idx] = val;
   endtask

   task automatic program_sizes(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                                input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
      write_dim(CSR_A_ROWS, ar);
      write_dim(CSR_A_COLS, ac);
      write_dim(CSR_B_ROWS, br);
      write_dim(CSR_B_COLS, bc);
      @(negedge clock);
      csr_valid <= 1'b0;
      dim_sets++;
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid)
         @(posedge clock);
      while (due_elems.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
   endtask

   task automatic run_phase(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                            input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc,
                            input int n_rand, input bit lead_compute, input bit with_hold);
      program_sizes(ar, ac, br, bc);
      burst_mode = ($urandom_range(0, 3) == 0);
      rsp_eager  = ($urandom_range(0, 3) == 0);
      if (with_hold)
         hold_armed = 1'b1;
      if (lead_compute)
         queue_compute();
      queue_random(n_rand);
      drain();
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
      end else if (pending_reqs.size() == 0) begin
         req_valid <= 1'b0;
      end else if (idle_count < pending_reqs[0].gap) begin
         idle_count++;
         req_valid <= 1'b0;
      end else begin
         next_req = pending_reqs.pop_front();
         idle_count = 0;
         req_payload <= next_req.body;
         req_valid <= 1'b1;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_armed && !hold_spent) begin
            hold_left = LONG_HOLD;
            hold_spent = 1'b1;
         end
         if (rsp_taken)
            rsp_wait = rsp_eager ? 0 : $urandom_range(0, 6);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            if (due_elems.size() == 0) begin
               $error("unexpected result at row %0d col %0d", rsp_payload.out_row,
                      rsp_payload.out_col);
               fail_count++;
            end else begin
               next_due = due_elems.pop_front();
               check_part("out_row", next_due.out_row, rsp_payload.out_row);
               check_part("out_col", next_due.out_col, rsp_payload.out_col);
               check_part("out_re", next_due.out_re, rsp_payload.out_re);
               check_part("out_im", next_due.out_im, rsp_payload.out_im);
               check_part("dim_mismatch", next_due.dim_mismatch, rsp_payload.dim_mismatch);
               check_part("last", next_due.last, rsp_payload.last);
               elems_seen++;
               if (next_due.dim_mismatch)
                  passthru++;
            end
         end
         if (req_valid && !req_stall) begin
            apply_request(req_payload);
            reqs_done++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock) cycle_count++;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (12)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // saturation both ways on the reset size
      queue_req(REQ_LOAD_A, 0, 0, 32'h7FFFFFFF, 32'h80000000);
      queue_req(REQ_LOAD_A, 0, 1, 32'h80000000, 32'h7FFFFFFF);
      queue_req(REQ_LOAD_A, 1, 0, 32'h00000000, 32'hFFFFFFFF);
      queue_req(REQ_LOAD_A, 1, 1, 32'h00010000, 32'h00000000);
      queue_req(REQ_LOAD_B, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
      queue_req(REQ_LOAD_B, 0, 1, 32'h80000000, 32'h80000000);
      queue_req(REQ_LOAD_B, 1, 0, 32'h00010000, 32'h00010000);
      queue_req(REQ_LOAD_B, 1, 1, 32'hFFFF8001, 32'h00000003);
      queue_compute();
      // loads outside the configured size, unused request type
      queue_req(REQ_LOAD_A, 7, 7, 32'hFFFFFFFF, 32'h00000000);
      queue_req(REQ_LOAD_B, 7, 7, 32'h00000000, 32'hFFFFFFFF);
      queue_req(REQ_UNUSED, 7, 7, $urandom(), $urandom());
      // floor rounding of negative fractions, back to back computes
      queue_req(REQ_LOAD_A, 0, 0, 32'h00018000, 32'hFFFF4000);
      queue_compute();
      queue_compute();
      drain();

      run_phase(4'd1, 4'd1, 4'd1, 4'd1, 8, 1'b0, 1'b0);
      run_phase(4'd15, 4'd1, 4'd1, 4'd15, 4, 1'b1, 1'b0);
      run_phase(4'd3, 4'd3, 4'd3, 4'd3, 10, 1'b1, 1'b1);
      run_phase(4'd3, 4'd5, 4'd4, 4'd2, 6, 1'b1, 1'b0);
      run_phase(4'd2, 4'd0, 4'd0, 4'd3, 4, 1'b1, 1'b0);
      run_phase(4'd0, 4'd3, 4'd3, 4'd2, 4, 1'b1, 1'b0);
      run_phase(4'd1, 4'd15, 4'd8, 4'd1, 2, 1'b1, 1'b0);
      repeat (3) begin
         automatic logic [DIM_W-1:0] inner = rand_dim();
         run_phase(rand_dim(), inner, ($urandom_range(0, 3) != 0) ? inner : rand_dim(),
                   rand_dim(), 5, 1'b0, 1'b0);
      end

      $display("covered %0d requests including %0d products over %0d dimension settings",
               reqs_done, runs_done, dim_sets);
      $display("checked %0d result elements, %0d of them A passed through", elems_seen,
               passthru);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
